[hdl/bmpru_pkg.sv]
// shared types, register indexes and colour helpers for the bitmap row unpacker
`default_nettype none

package bmpru_pkg;

    localparam int MaxWidth     = 4096;
    localparam int MaxHeight    = 4096;
    localparam int PaletteDepth = 256;

    localparam int DimW   = 13;
    localparam int CoordW = 12;
    localparam int PosW   = 15;
    localparam int PalAw  = $clog2(PaletteDepth);

    typedef enum logic [1:0] {
        FMT_4BPP  = 2'd0,
        FMT_8BPP  = 2'd1,
        FMT_24BPP = 2'd2,
        FMT_32BPP = 2'd3
    } pix_fmt_t;

    typedef enum logic [1:0] {
        CFG_PIXEL_FORMAT = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_idx_t;

    localparam logic MODE_PALETTE = 1'b0;
    localparam logic MODE_DATA    = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [7:0]  palette_index;
        logic [31:0] palette_color;
        logic [7:0]  data_byte;
    } in_beat_t;

    typedef struct packed {
        logic [31:0]       pixel_word;
        logic [CoordW-1:0] dest_row;
        logic [CoordW-1:0] dest_col;
        logic              run_last;
        logic              image_done;
    } out_beat_t;

    // palette entry is b,g,r,x from the low byte up; output wants r,g,b,x
    function automatic logic [31:0] pal_to_rgba(input logic [31:0] c);
        return {c[31:24], c[7:0], c[15:8], c[23:16]};
    endfunction

    function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                  input logic [DimW-1:0] maxv);
        logic [DimW-1:0] r;
        if (v == '0) begin
            r = DimW'(1);
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/bitmap_row_unpack_to_rgba32.sv]
// top level: bitmap pixel-data byte stream to tagged 32-bit pixels
//
// s_ channel: one beat is either a palette entry write (mode 0) or the next
// byte of bitmap pixel data in file order, bottom row first, rows padded to
// a 4-byte pitch. m_ channel: one beat is one pixel with its top-down row
// and column, run_last on the final pixel a beat caused and image_done on
// the final pixel of the image. The cfg_ port writes pixel_format,
// image_width and image_height; any such write restarts the stream position.
// A pixel beat takes the palette read and loads the hold stage at the edge that
// accepts it, then moves to the output register once that register is free, and
// is shown on m_ from there. Throughput: one input beat per cycle while s_ready
// is high; at 4 bpp a byte gives up to two pixels, and the single-pixel output
// takes them in turn, so the next byte waits for the second. Padding bytes and
// palette writes give no output.
// Reset clears the stream position and registers (32 bpp, 1 x 1); palette
// contents are undefined until written. When m_ready is low the output
// register and the hold stage fill and then s_ready drops; no beat is lost.
`default_nettype none

module bitmap_row_unpack_to_rgba32 (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire bmpru_pkg::in_beat_t     s_payload,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output bmpru_pkg::out_beat_t         m_payload,
    input  wire logic                    cfg_wr_en,
    input  wire logic [1:0]              cfg_index,
    input  wire logic [bmpru_pkg::DimW-1:0] cfg_wdata
);
    import bmpru_pkg::*;

    localparam logic [DimW-1:0] MaxW = DimW'(MaxWidth);
    localparam logic [DimW-1:0] MaxH = DimW'(MaxHeight);

    // configuration
    pix_fmt_t        fmt_reg;
    logic [DimW-1:0] width_reg, height_reg;

    // stream position
    logic [PosW-1:0] byte_pos_reg, byte_pos_next;
    logic [11:0]     src_row_reg, src_row_next;
    logic [DimW-1:0] col_reg, col_next;
    logic [1:0]      phase_reg, phase_next;
    logic [23:0]     asm_reg, asm_next;

    // hold stage between palette read and output register
    logic              b_valid_reg;
    logic              b_two_reg;
    logic              b_sel_reg;
    logic              b_pal_reg;
    logic [31:0]       b_word_reg;
    logic [CoordW-1:0] b_row_reg;
    logic [CoordW-1:0] b_col_reg;
    logic              b_done0_reg, b_done1_reg;
    logic [31:0]       rd0_reg, rd1_reg;

    out_beat_t m_payload_reg, m_payload_next;
    logic      m_valid_reg;

    logic [31:0] pal_mem [PaletteDepth];

    logic            acc, acc_data, acc_pal;
    logic            out_load, b_last_out;
    logic [PosW-1:0] used, pitch, pos_inc;
    logic            in_used, a_emit, a_two;
    logic [31:0]     a_word;
    logic            a_pal;
    logic [DimW-1:0] col_inc1;
    logic [7:0]      d;
    logic [PalAw-1:0] rd_addr0, rd_addr1;
    logic [DimW-1:0] row_ext;
    logic            last_row;
    logic            cfg_hit;

    assign d        = s_payload.data_byte;
    assign out_load = !m_valid_reg || m_ready;
    assign b_last_out = b_valid_reg && out_load && (!b_two_reg || b_sel_reg);
    assign s_ready  = !b_valid_reg || b_last_out;
    assign acc      = s_valid && s_ready;
    assign acc_data = acc && (s_payload.mode == MODE_DATA);
    assign acc_pal  = acc && (s_payload.mode == MODE_PALETTE);
    assign cfg_hit  = cfg_wr_en && (cfg_idx_t'(cfg_index) != CFG_UNUSED);

    // row geometry
    always_comb begin
        unique case (fmt_reg)
            FMT_4BPP:  used = ({2'b00, width_reg} + PosW'(1)) >> 1;
            FMT_8BPP:  used = {2'b00, width_reg};
            FMT_24BPP: used = {1'b0, width_reg, 1'b0} + {2'b00, width_reg};
            default:   used = {width_reg, 2'b00};
        endcase
        pitch   = (used + PosW'(3)) & ~PosW'(3);
        pos_inc = byte_pos_reg + PosW'(1);
        in_used = byte_pos_reg < used;
    end

    assign col_inc1 = col_reg + DimW'(1);
    assign row_ext  = {1'b0, src_row_reg};
    assign last_row = row_ext == (height_reg - DimW'(1));

    // per-byte unpack
    always_comb begin
        a_emit     = 1'b0;
        a_two      = 1'b0;
        a_pal      = 1'b0;
        a_word     = '0;
        col_next   = col_reg;
        phase_next = phase_reg;
        asm_next   = asm_reg;
        rd_addr0   = d;
        rd_addr1   = {4'h0, d[3:0]};
        if (in_used) begin
            unique case (fmt_reg)
                FMT_4BPP: begin
                    a_emit   = 1'b1;
                    a_pal    = 1'b1;
                    a_two    = col_inc1 < width_reg;
                    rd_addr0 = {4'h0, d[7:4]};
                    col_next = a_two ? col_reg + DimW'(2) : col_inc1;
                end
                FMT_8BPP: begin
                    a_emit   = 1'b1;
                    a_pal    = 1'b1;
                    col_next = col_inc1;
                end
                FMT_24BPP: begin
                    if (phase_reg >= 2'd2) begin
                        a_emit     = 1'b1;
                        a_word     = {8'h00, d, asm_reg[15:0]};
                        col_next   = col_inc1;
                        phase_next = '0;
                        asm_next   = '0;
                    end else begin
                        asm_next   = asm_reg | 24'({16'h0000, d} << {phase_reg, 3'b000});
                        phase_next = phase_reg + 2'd1;
                    end
                end
                default: begin
                    if (phase_reg >= 2'd3) begin
                        a_emit     = 1'b1;
                        a_word     = {d, asm_reg};
                        col_next   = col_inc1;
                        phase_next = '0;
                        asm_next   = '0;
                    end else begin
                        asm_next   = asm_reg | 24'({16'h0000, d} << {phase_reg, 3'b000});
                        phase_next = phase_reg + 2'd1;
                    end
                end
            endcase
        end
        byte_pos_next = pos_inc;
        src_row_next  = src_row_reg;
        if (pos_inc >= pitch) begin
            byte_pos_next = '0;
            col_next      = '0;
            phase_next    = '0;
            asm_next      = '0;
            src_row_next  = last_row ? 12'd0 : src_row_reg + 12'd1;
        end
    end

    // configuration registers and stream position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg      <= FMT_32BPP;
            width_reg    <= DimW'(1);
            height_reg   <= DimW'(1);
            byte_pos_reg <= '0;
            src_row_reg  <= '0;
            col_reg      <= '0;
            phase_reg    <= '0;
            asm_reg      <= '0;
        end else if (cfg_hit) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_PIXEL_FORMAT: fmt_reg    <= pix_fmt_t'(cfg_wdata[1:0]);
                CFG_IMAGE_WIDTH:  width_reg  <= clamp_dim(cfg_wdata, MaxW);
                default:          height_reg <= clamp_dim(cfg_wdata, MaxH);
            endcase
            byte_pos_reg <= '0;
            src_row_reg  <= '0;
            col_reg      <= '0;
            phase_reg    <= '0;
            asm_reg      <= '0;
        end else if (acc_data) begin
            byte_pos_reg <= byte_pos_next;
            src_row_reg  <= src_row_next;
            col_reg      <= col_next;
            phase_reg    <= phase_next;
            asm_reg      <= asm_next;
        end
    end

    // palette store, two registered read ports
    always_ff @(posedge aclk) begin
        if (acc_pal) begin
            pal_mem[s_payload.palette_index] <= s_payload.palette_color;
        end
        if (acc_data) begin
            rd0_reg <= pal_mem[rd_addr0];
            rd1_reg <= pal_mem[rd_addr1];
        end
    end

    // hold stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            b_sel_reg   <= 1'b0;
        end else begin
            if (acc_data && a_emit) begin
                b_valid_reg <= 1'b1;
                b_sel_reg   <= 1'b0;
            end else if (b_last_out) begin
                b_valid_reg <= 1'b0;
                b_sel_reg   <= 1'b0;
            end else if (b_valid_reg && out_load) begin
                b_sel_reg   <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_data) begin
            b_two_reg   <= a_two;
            b_pal_reg   <= a_pal;
            b_word_reg  <= a_word;
            b_row_reg   <= CoordW'(height_reg - DimW'(1) - row_ext);
            b_col_reg   <= CoordW'(col_reg);
            b_done0_reg <= last_row && (col_reg == width_reg - DimW'(1));
            b_done1_reg <= last_row && (col_inc1 == width_reg - DimW'(1));
        end
    end

    // output register
    always_comb begin
        m_payload_next.pixel_word = b_pal_reg ? pal_to_rgba(b_sel_reg ? rd1_reg : rd0_reg)
                                              : b_word_reg;
        m_payload_next.dest_row   = b_row_reg;
        m_payload_next.dest_col   = b_col_reg + CoordW'(b_sel_reg);
        m_payload_next.run_last   = !b_two_reg || b_sel_reg;
        m_payload_next.image_done = b_sel_reg ? b_done1_reg : b_done0_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && b_valid_reg) begin
            m_payload_reg <= m_payload_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // checks
    a_stall_needs_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> b_valid_reg)
        else $error("input stalled with empty hold stage");

    a_emit_fills_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc_data && a_emit) |=> b_valid_reg)
        else $error("pixel beat did not reach hold stage");

    a_sel_only_pairs: assert property (@(posedge aclk) disable iff (!aresetn)
        b_sel_reg |-> (b_valid_reg && b_two_reg))
        else $error("second pixel selected without a pair");

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_payload_reg.image_done) |-> m_payload_reg.run_last)
        else $error("image end not on last pixel of its beat");

endmodule

`default_nettype wire
